// File: rtl/bbo_pkg.sv
`timescale 1ns / 1ps

package bbo_pkg;

  localparam int MAX_BOXES_DEF = 16;
  localparam int MAX_DIM_DEF   = 4096;

  localparam int COORD_W = 13;
  localparam int PIX_W   = 12;
  localparam int CH_W    = 8;
  localparam int CLASS_W = 8;
  localparam int COLOR_W = 4;
  localparam int IDX_W   = 4;
  localparam int DIM_W   = 13;
  localparam int COUNT_W = 5;
  // signed work width for clamped corners and pixel deltas
  localparam int CW      = 15;

  localparam int BORDER  = 2;
  localparam int LABEL_W = 16;
  localparam int LABEL_H = 8;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_COUNT    = 2'd2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
    logic [COLOR_W-1:0]        color;
  } box_t;

  typedef struct packed {
    logic signed [CW-1:0] x_max;
    logic signed [CW-1:0] y_max;
    logic [COUNT_W-1:0]   count;
  } cfg_t;

  function automatic logic [3*CH_W-1:0] palette(logic [COLOR_W-1:0] idx);
    logic [3*CH_W-1:0] c;
    unique case (idx)
      4'd0:    c = 24'hFF3B30;
      4'd1:    c = 24'h34C759;
      4'd2:    c = 24'h007AFF;
      4'd3:    c = 24'hFFCC00;
      4'd4:    c = 24'hAF52DE;
      4'd5:    c = 24'hFF9500;
      4'd6:    c = 24'h5AC8FA;
      4'd7:    c = 24'hFF2D55;
      4'd8:    c = 24'h00C7BE;
      4'd9:    c = 24'h8E8E93;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/bbo_cfg_regs.sv
`timescale 1ns / 1ps

module bbo_cfg_regs import bbo_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o
);

  localparam int RST_W = (RESET_WIDTH > MAX_DIM) ? MAX_DIM : RESET_WIDTH;
  localparam int RST_H = (RESET_HEIGHT > MAX_DIM) ? MAX_DIM : RESET_HEIGHT;
  localparam logic [DIM_W:0] DIM_MAX = (DIM_W + 1)'(MAX_DIM);

  logic signed [CW-1:0] x_max_q, y_max_q, lim_d;
  logic [COUNT_W-1:0]   count_q;
  logic [DIM_W:0]       data_ext, data_sat;

  // store the saturated dimension minus one, ready for clamping
  always_comb begin
    data_ext = {1'b0, cfg_data_i};
    data_sat = (data_ext > DIM_MAX) ? DIM_MAX : data_ext;
    lim_d    = $signed({1'b0, data_sat}) - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_max_q <= CW'(RST_W - 1);
      y_max_q <= CW'(RST_H - 1);
      count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  x_max_q <= lim_d;
        REG_IMAGE_HEIGHT: y_max_q <= lim_d;
        REG_BOX_COUNT:    count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.x_max = x_max_q;
  assign cfg_o.y_max = y_max_q;
  assign cfg_o.count = count_q;

endmodule

// File: rtl/bbo_box_table.sv
`timescale 1ns / 1ps

module bbo_box_table import bbo_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [IDX_W-1:0]          wr_idx_i,
  input  logic signed [COORD_W-1:0] left_i,
  input  logic signed [COORD_W-1:0] top_i,
  input  logic signed [COORD_W-1:0] right_i,
  input  logic signed [COORD_W-1:0] bottom_i,
  input  logic [CLASS_W-1:0]        class_i,
  output box_t                      entries_o [MAX_BOXES]
);

  box_t table_q [MAX_BOXES];
  box_t entry_d;

  // class mod 10 via reciprocal multiply, exact for 8-bit classes
  function automatic logic [COLOR_W-1:0] mod10(logic [CLASS_W-1:0] c);
    logic [15:0]        prod;
    logic [4:0]         quo;
    logic [CLASS_W-1:0] rem;
    prod = 16'(c) * 16'd205;
    quo  = prod[15:11];
    rem  = c - (CLASS_W'(quo) * CLASS_W'(10));
    return rem[COLOR_W-1:0];
  endfunction

  always_comb begin
    entry_d.left   = left_i;
    entry_d.top    = top_i;
    entry_d.right  = right_i;
    entry_d.bottom = bottom_i;
    entry_d.color  = mod10(class_i);
  end

  // slots at or beyond the table depth are dropped
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_slot
    always_ff @(posedge clk_i) begin
      if (wr_en_i && (32'(wr_idx_i) == i)) begin
        table_q[i] <= entry_d;
      end
    end
    assign entries_o[i] = table_q[i];
  end

endmodule

// File: rtl/bbo_box_hit.sv
`timescale 1ns / 1ps

module bbo_box_hit import bbo_pkg::*; (
  input  box_t                 entry_i,
  input  logic signed [CW-1:0] x_max_i,
  input  logic signed [CW-1:0] y_max_i,
  input  logic [PIX_W-1:0]     px_i,
  input  logic [PIX_W-1:0]     py_i,
  output logic                 hit_o
);

  localparam logic signed [CW-1:0] BORDER_S = CW'(BORDER);
  localparam logic signed [CW-1:0] LW_S     = CW'(LABEL_W);
  localparam logic signed [CW-1:0] LH_S     = CW'(LABEL_H);

  logic signed [CW-1:0] l, t, r, b, x1, y1, x2, y2, px, py;
  logic signed [CW-1:0] dx_lo, dx_hi, dy_lo, dy_hi;
  logic nonempty, in_box, border, label;

  always_comb begin
    l  = $signed({{(CW-COORD_W){entry_i.left[COORD_W-1]}},   entry_i.left});
    t  = $signed({{(CW-COORD_W){entry_i.top[COORD_W-1]}},    entry_i.top});
    r  = $signed({{(CW-COORD_W){entry_i.right[COORD_W-1]}},  entry_i.right});
    b  = $signed({{(CW-COORD_W){entry_i.bottom[COORD_W-1]}}, entry_i.bottom});
    px = $signed({{(CW-PIX_W){1'b0}}, px_i});
    py = $signed({{(CW-PIX_W){1'b0}}, py_i});

    x1 = (l < 0) ? '0 : l;
    y1 = (t < 0) ? '0 : t;
    x2 = (r > x_max_i) ? x_max_i : r;
    y2 = (b > y_max_i) ? y_max_i : b;

    dx_lo = px - x1;
    dx_hi = x2 - px;
    dy_lo = py - y1;
    dy_hi = y2 - py;

    nonempty = (x2 > x1) && (y2 > y1);
    in_box   = (px >= x1) && (px <= x2) && (py >= y1) && (py <= y2);
    border   = (dx_lo < BORDER_S) || (dx_hi < BORDER_S) ||
               (dy_lo < BORDER_S) || (dy_hi < BORDER_S);
    // px < x1 + min(x2-x1, 16) splits into two compares
    label    = (px < x2) && (dx_lo < LW_S) && (py < y2) && (dy_lo < LH_S);

    hit_o = nonempty && in_box && (border || label);
  end

endmodule

// File: rtl/bounding_box_overlay.sv
`timescale 1ns / 1ps

// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_stall_o   | operation, box load fields, pixel fields
// out     | output    | out_valid_o / out_stall_i | red/green/blue out, painted
// cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// one item per cycle unless stalled; a pixel goes through the input then the result register
// all table entries are tested by parallel hit lanes between the input and result registers
// a box load writes its table slot as it leaves the input register and gives no result
// reset clears the valid flags and resets the config registers; the box table is not cleared
// out_stall_i holds the result register and stalls the input only behind a waiting pixel

module bounding_box_overlay import bbo_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF,
  parameter int MAX_DIM   = MAX_DIM_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,

  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [DIM_W-1:0]          cfg_data_i,

  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [0:0]                operation_i,
  input  logic [IDX_W-1:0]          box_index_i,
  input  logic signed [COORD_W-1:0] box_left_i,
  input  logic signed [COORD_W-1:0] box_top_i,
  input  logic signed [COORD_W-1:0] box_right_i,
  input  logic signed [COORD_W-1:0] box_bottom_i,
  input  logic [CLASS_W-1:0]        box_class_i,
  input  logic [PIX_W-1:0]          pixel_column_i,
  input  logic [PIX_W-1:0]          pixel_row_i,
  input  logic [CH_W-1:0]           red_in_i,
  input  logic [CH_W-1:0]           green_in_i,
  input  logic [CH_W-1:0]           blue_in_i,

  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [CH_W-1:0]           red_out_o,
  output logic [CH_W-1:0]           green_out_o,
  output logic [CH_W-1:0]           blue_out_o,
  output logic                      painted_o
);

  cfg_t cfg;
  box_t entries [MAX_BOXES];

  logic                      s1_v_q;
  op_e                       s1_op_q;
  logic [IDX_W-1:0]          s1_idx_q;
  logic signed [COORD_W-1:0] s1_left_q, s1_top_q, s1_right_q, s1_bottom_q;
  logic [CLASS_W-1:0]        s1_class_q;
  logic [PIX_W-1:0]          s1_col_q, s1_row_q;
  logic [CH_W-1:0]           s1_r_q, s1_g_q, s1_b_q;

  logic                      out_v_q, painted_q;
  logic [CH_W-1:0]           r_q, g_q, b_q;

  logic                      out_rdy, s1_adv, in_acc, tbl_we;
  logic [MAX_BOXES-1:0]      hit, lane_en;
  logic                      found;
  logic [COLOR_W-1:0]        sel_color;
  logic [3*CH_W-1:0]         rgb;

  bbo_cfg_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign tbl_we = s1_v_q && (s1_op_q == OP_LOAD);

  bbo_box_table #(
    .MAX_BOXES (MAX_BOXES)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (tbl_we),
    .wr_idx_i  (s1_idx_q),
    .left_i    (s1_left_q),
    .top_i     (s1_top_q),
    .right_i   (s1_right_q),
    .bottom_i  (s1_bottom_q),
    .class_i   (s1_class_q),
    .entries_o (entries)
  );

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_lane
    assign lane_en[i] = (32'(cfg.count) > i);

    bbo_box_hit u_hit (
      .entry_i (entries[i]),
      .x_max_i (cfg.x_max),
      .y_max_i (cfg.y_max),
      .px_i    (s1_col_q),
      .py_i    (s1_row_q),
      .hit_o   (hit[i])
    );
  end

  // highest index among matching boxes wins
  always_comb begin
    found     = 1'b0;
    sel_color = '0;
    for (int i = 0; i < MAX_BOXES; i++) begin
      if (lane_en[i] && hit[i]) begin
        found     = 1'b1;
        sel_color = entries[i].color;
      end
    end
    rgb = palette(sel_color);
  end

  assign out_rdy    = !out_v_q || !out_stall_i;
  assign s1_adv     = s1_v_q && ((s1_op_q == OP_LOAD) || out_rdy);
  assign in_stall_o = !rst_ni || (s1_v_q && !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv && (s1_op_q == OP_PIXEL)) begin
        out_v_q <= 1'b1;
      end else if (out_rdy) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q     <= op_e'(operation_i);
      s1_idx_q    <= box_index_i;
      s1_left_q   <= box_left_i;
      s1_top_q    <= box_top_i;
      s1_right_q  <= box_right_i;
      s1_bottom_q <= box_bottom_i;
      s1_class_q  <= box_class_i;
      s1_col_q    <= pixel_column_i;
      s1_row_q    <= pixel_row_i;
      s1_r_q      <= red_in_i;
      s1_g_q      <= green_in_i;
      s1_b_q      <= blue_in_i;
    end
    if (s1_adv && (s1_op_q == OP_PIXEL)) begin
      painted_q <= found;
      r_q       <= found ? rgb[3*CH_W-1:2*CH_W] : s1_r_q;
      g_q       <= found ? rgb[2*CH_W-1:CH_W]   : s1_g_q;
      b_q       <= found ? rgb[CH_W-1:0]        : s1_b_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign red_out_o   = r_q;
  assign green_out_o = g_q;
  assign blue_out_o  = b_q;
  assign painted_o   = painted_q;

endmodule

// File: rtl/bbo_checker.sv
`timescale 1ns / 1ps

module bbo_checker import bbo_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic [0:0]      operation_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [CH_W-1:0] red_out_o,
  input logic [CH_W-1:0] green_out_o,
  input logic [CH_W-1:0] blue_out_o,
  input logic            painted_o
);

  // a waiting result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable({red_out_o, green_out_o, blue_out_o, painted_o}))
    else $error("stalled result changed");

  // an empty result register never backs up the input
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // a new result only follows a pixel item taken at the input
  a_result_from_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && !in_stall_o && (operation_i == OP_PIXEL), 2))
    else $error("result without a pixel item");

endmodule

bind bounding_box_overlay bbo_checker u_bbo_checker (.*);
